>>> hw/rtl/cdc_pkg.sv
package cdc_pkg;

	localparam int REF_W = 16;
	localparam int POS_W = 32;
	localparam int CNT_W = 32;
	localparam int OP_W  = 4;

	localparam int TABLE_DEPTH_DEF = 256;

	// cigar operation codes
	localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
	localparam logic [OP_W-1:0] OP_SKIP_FWD  = 4'd1;
	localparam logic [OP_W-1:0] OP_SKIP_REV  = 4'd2;
	localparam logic [OP_W-1:0] OP_MATCH_FWD = 4'd3;
	localparam logic [OP_W-1:0] OP_MATCH_REV = 4'd4;
	localparam logic [OP_W-1:0] OP_DEL_FWD   = 4'd5;
	localparam logic [OP_W-1:0] OP_DEL_REV   = 4'd6;
	localparam logic [OP_W-1:0] OP_INS_A     = 4'd7;
	localparam logic [OP_W-1:0] OP_INS_B     = 4'd8;
	localparam logic [OP_W-1:0] OP_FUSION    = 4'd9;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// one slot of the count table
	typedef struct packed {
		logic             valid;
		logic [REF_W-1:0] ref_id;
		logic [POS_W-1:0] left;
		logic [POS_W-1:0] right;
		logic [CNT_W-1:0] count;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic clr;
		logic start;
		logic next;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		logic is_del;
		logic clr_last;
		logic hit;
		logic empty;
		logic last_probe;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/cdc_op_if.sv
interface cdc_op_if;
	import cdc_pkg::*;

	logic             valid;
	logic             ready;
	logic             first_of_hit;
	logic [POS_W-1:0] hit_left;
	logic [REF_W-1:0] ref_primary;
	logic [REF_W-1:0] ref_fused;
	logic [OP_W-1:0]  op_code;
	logic [POS_W-1:0] op_length;

	modport source (
		output valid, first_of_hit, hit_left, ref_primary, ref_fused, op_code, op_length,
		input  ready
	);
	modport sink (
		input  valid, first_of_hit, hit_left, ref_primary, ref_fused, op_code, op_length,
		output ready
	);
endinterface

>>> hw/rtl/cdc_del_if.sv
interface cdc_del_if;
	import cdc_pkg::*;

	logic             valid;
	logic             ready;
	logic [REF_W-1:0] del_ref;
	logic [POS_W-1:0] del_left;
	logic [POS_W-1:0] del_right;
	logic [CNT_W-1:0] support_count;
	logic             table_full;

	modport source (
		output valid, del_ref, del_left, del_right, support_count, table_full,
		input  ready
	);
	modport sink (
		input  valid, del_ref, del_left, del_right, support_count, table_full,
		output ready
	);
endinterface

>>> hw/rtl/cdc_ram.sv
module cdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/cdc_ctrl.sv
module cdc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  cdc_pkg::sts_t sts,
	output cdc_pkg::cmd_t cmd
);
	import cdc_pkg::*;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_CMP
	} state_t;

	state_t state_q;
	logic   done;

	// search ends on a match, on a free slot or after the whole table
	assign done = sts.hit || sts.empty || sts.last_probe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (sts.in_valid && sts.is_del) state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (done && sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLR:  cmd.clr = 1'b1;
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_RD:   cmd.start = 1'b1;
			ST_CMP: begin
				cmd.finish = done && sts.out_free;
				cmd.next   = !done;
			end
			default: cmd = '0;
		endcase
	end
endmodule

>>> hw/rtl/cdc_dp.sv
module cdc_dp #(
	parameter int TABLE_DEPTH = cdc_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cdc_op_if.sink        cigar_op,
	cdc_del_if.source     deletion,
	input  cdc_pkg::cmd_t cmd,
	output cdc_pkg::sts_t sts
);
	import cdc_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = $bits(entry_t);
	localparam int KEY_W   = REF_W + 2 * POS_W;

	logic [POS_W-1:0] pos_q;
	logic             fus_q;
	logic [REF_W-1:0] key_ref_q;
	logic [POS_W-1:0] key_left_q;
	logic [POS_W-1:0] key_right_q;
	logic [IDX_W-1:0] probe_q;
	logic [IDX_W-1:0] nprobe_q;
	logic [IDX_W-1:0] clr_q;

	logic             out_valid_q;
	logic [REF_W-1:0] out_ref_q;
	logic [POS_W-1:0] out_left_q;
	logic [POS_W-1:0] out_right_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_full_q;

	logic             accept;
	logic [POS_W-1:0] pos_eff;
	logic             fus_eff;
	logic [POS_W-1:0] pos_nxt;
	logic             fus_nxt;
	logic [POS_W-1:0] left_nxt;
	logic [POS_W-1:0] right_nxt;
	logic             is_del;

	logic [KEY_W-1:0] key;
	logic [IDX_W-1:0] fold;
	logic [IDX_W:0]   fold_ext;
	logic [IDX_W-1:0] hash;
	logic [IDX_W-1:0] probe_nxt;

	entry_t           rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	entry_t           wr_entry;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [CNT_W-1:0] cnt_inc;

	assign accept = cigar_op.valid && cmd.in_ready;
	assign cigar_op.ready = cmd.in_ready;
	assign is_del = cigar_op.op_code inside {OP_DEL_FWD, OP_DEL_REV};

	// position walk for the op being taken
	always_comb begin
		pos_eff   = cigar_op.first_of_hit ? cigar_op.hit_left : pos_q;
		fus_eff   = cigar_op.first_of_hit ? 1'b0 : fus_q;
		pos_nxt   = pos_eff;
		fus_nxt   = fus_eff;
		left_nxt  = pos_eff - POS_W'(1);
		right_nxt = pos_eff + cigar_op.op_length;
		case (cigar_op.op_code)
			OP_SKIP_FWD, OP_MATCH_FWD, OP_DEL_FWD: pos_nxt = pos_eff + cigar_op.op_length;
			OP_SKIP_REV, OP_MATCH_REV:             pos_nxt = pos_eff - cigar_op.op_length;
			OP_DEL_REV: begin
				pos_nxt   = pos_eff + cigar_op.op_length;
				left_nxt  = pos_eff - cigar_op.op_length;
				right_nxt = pos_eff + POS_W'(1);
			end
			OP_FUSION: begin
				pos_nxt = cigar_op.op_length;
				fus_nxt = 1'b1;
			end
			default: pos_nxt = pos_eff;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fus_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_nxt;
			fus_q <= fus_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_del) begin
			key_ref_q   <= fus_eff ? cigar_op.ref_fused : cigar_op.ref_primary;
			key_left_q  <= left_nxt;
			key_right_q <= right_nxt;
		end
	end

	// xor fold of the key into a table index
	assign key = {key_ref_q, key_left_q, key_right_q};

	always_comb begin
		fold = '0;
		for (int i = 0; i < KEY_W; i++) begin
			fold[i % IDX_W] = fold[i % IDX_W] ^ key[i];
		end
		fold_ext = {1'b0, fold};
		if (fold_ext >= (IDX_W+1)'(TABLE_DEPTH)) begin
			hash = IDX_W'(fold_ext - (IDX_W+1)'(TABLE_DEPTH));
		end else begin
			hash = fold;
		end
	end

	assign probe_nxt = (probe_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : probe_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			probe_q  <= hash;
			nprobe_q <= '0;
		end else if (cmd.next) begin
			probe_q  <= probe_nxt;
			nprobe_q <= nprobe_q + IDX_W'(1);
		end
	end

	// table slot compare
	assign rd_entry = entry_t'(rd_data);
	assign cnt_inc  = (rd_entry.count == CNT_MAX) ? CNT_MAX : rd_entry.count + CNT_W'(1);

	always_comb begin
		sts            = '0;
		sts.in_valid   = cigar_op.valid;
		sts.is_del     = is_del;
		sts.clr_last   = (clr_q == IDX_W'(TABLE_DEPTH - 1));
		sts.hit        = rd_entry.valid && rd_entry.ref_id == key_ref_q
		                 && rd_entry.left == key_left_q && rd_entry.right == key_right_q;
		sts.empty      = !rd_entry.valid;
		sts.last_probe = (nprobe_q == IDX_W'(TABLE_DEPTH - 1));
		sts.out_free   = !out_valid_q || deletion.ready;
	end

	always_comb begin
		wr_entry        = '0;
		wr_entry.ref_id = key_ref_q;
		wr_entry.left   = key_left_q;
		wr_entry.right  = key_right_q;
		if (!cmd.clr) begin
			wr_entry.valid = 1'b1;
			wr_entry.count = sts.hit ? cnt_inc : CNT_W'(1);
		end
	end

	assign ram_we    = cmd.clr || (cmd.finish && (sts.hit || sts.empty));
	assign ram_waddr = cmd.clr ? clr_q : probe_q;
	assign ram_re    = cmd.start || cmd.next;
	assign ram_raddr = cmd.start ? hash : probe_nxt;

	cdc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ENTRY_W'(wr_entry)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (deletion.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_ref_q   <= key_ref_q;
			out_left_q  <= key_left_q;
			out_right_q <= key_right_q;
			if (sts.hit) begin
				out_count_q <= cnt_inc;
				out_full_q  <= 1'b0;
			end else if (sts.empty) begin
				out_count_q <= CNT_W'(1);
				out_full_q  <= 1'b0;
			end else begin
				out_count_q <= '0;
				out_full_q  <= 1'b1;
			end
		end
	end

	assign deletion.valid         = out_valid_q;
	assign deletion.del_ref       = out_ref_q;
	assign deletion.del_left      = out_left_q;
	assign deletion.del_right     = out_right_q;
	assign deletion.support_count = out_count_q;
	assign deletion.table_full    = out_full_q;
endmodule

>>> hw/rtl/cigar_deletion_counter_top.sv
// cigar deletion counter
// cigar_op (sink) takes one cigar operation per transfer with the alignment's
// left coordinate, both reference ids, op code and length. deletion (source)
// gives one transfer per deletion op: reference, left and right flank, the
// supporting count after the update (saturating) and a flag for a key that
// was dropped because the count table is full; other ops give nothing.
// a non-deletion op is taken in idle and the next op may follow at once.
// a deletion starts a table read, then slots are compared one by one until
// a match, a free slot or the last slot; the table is a hashed, linearly
// probed ram with one write and one read port and one read per cycle, so one
// slot is read in the usual case and TABLE_DEPTH at most when full. after
// reset a sweep clears every slot's valid mark, with cigar_op.ready low.
// the result sits in an output register, so the next op is taken while a
// result waits; if the receiver stalls, a second deletion holds in its last
// compare step until the register frees, with ready low meanwhile.
module cigar_deletion_counter_top #(
	parameter int TABLE_DEPTH = cdc_pkg::TABLE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cdc_op_if.sink    cigar_op,
	cdc_del_if.source deletion
);
	import cdc_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: clear sweep, idle, table read, compare and probe
	cdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath: position walk, key build, count table, output register
	cdc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cigar_op (cigar_op),
		.deletion (deletion),
		.cmd      (cmd),
		.sts      (sts)
	);

	// a finished search never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n) cmd.finish |-> sts.out_free)
		else $error("result register overwritten");

	// only one table action per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.start, cmd.next, cmd.finish, cmd.in_ready}))
		else $error("conflicting table commands");

	// a dropped key carries no count
	assert property (@(posedge clk) disable iff (!arst_n)
		deletion.valid && deletion.table_full |-> deletion.support_count == '0)
		else $error("dropped key with nonzero count");

	// a search always follows the table read that a deletion starts
	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |=> !cmd.in_ready)
		else $error("search abandoned after start");
endmodule
